FILE: hdl/smlc_pkg.sv
// shared constants and types for the streaming substring matcher
`timescale 1ns / 1ps
`default_nettype none

package smlc_pkg;

   // default sizes for the top level parameters
   localparam int MAX_PATTERN_DEF = 32;
   localparam int LINE_BITS_DEF   = 32;
   localparam int COLUMN_BITS_DEF = 16;

   // configuration port layout
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 64;
   localparam int LENGTH_BITS    = 6;
   localparam int PATTERN_WORDS  = 4;
   localparam int CFG_BYTES      = 32;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LENGTH      = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BYTES_0_7   = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BYTES_8_15  = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BYTES_16_23 = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BYTES_24_31 = 3'd4;

   // text and result field widths
   localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
   localparam int LINE_OUT_BITS   = 32;
   localparam int COLUMN_OUT_BITS = 16;
   localparam int OFFSET_BITS     = 32;

   // per cell compare control: aligned pattern byte, cell in use, cell holds match start
   typedef struct packed {
      logic [7:0] pat;
      logic       used;
      logic       pick;
   } cell_ctl_type;

endpackage

`default_nettype wire

FILE: hdl/smlc_cell.sv
// one window cell: holds a text byte with its column and line, compares it to the pattern
`timescale 1ns / 1ps
`default_nettype none

module smlc_cell #(
   parameter int LINE_BITS   = smlc_pkg::LINE_BITS_DEF,
   parameter int COLUMN_BITS = smlc_pkg::COLUMN_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   shift_en,
   input  wire logic [7:0]             byte_prev,
   input  wire logic [COLUMN_BITS-1:0] column_prev,
   input  wire logic [LINE_BITS-1:0]   line_prev,
   input  wire smlc_pkg::cell_ctl_type ctl,
   output logic [7:0]                  byte_out,
   output logic [COLUMN_BITS-1:0]      column_out,
   output logic [LINE_BITS-1:0]        line_out,
   output logic                        match,
   output logic [COLUMN_BITS-1:0]      column_pick,
   output logic [LINE_BITS-1:0]        line_pick
);

   logic [7:0]             byte_ff;
   logic [COLUMN_BITS-1:0] column_ff;
   logic [LINE_BITS-1:0]   line_ff;

   // take the neighbor's contents when an item enters the window
   always_ff @(posedge clock) begin
      if (shift_en) begin
         byte_ff   <= byte_prev;
         column_ff <= column_prev;
         line_ff   <= line_prev;
      end
   end

   assign byte_out   = byte_ff;
   assign column_out = column_ff;
   assign line_out   = line_ff;

   // cells past the pattern length always agree
   assign match = !ctl.used || (byte_ff == ctl.pat);

   // only the cell that holds the first matched byte drives the position
   assign column_pick = ctl.pick ? column_ff : '0;
   assign line_pick   = ctl.pick ? line_ff : '0;

endmodule

`default_nettype wire

FILE: hdl/smlc_align.sv
// lines the configured pattern up with the window cells for the active length
`timescale 1ns / 1ps
`default_nettype none

module smlc_align #(
   parameter int MAX_PATTERN = smlc_pkg::MAX_PATTERN_DEF,
   localparam int LEN_W      = $clog2(MAX_PATTERN + 1)
) (
   input  wire logic                                  clock,
   input  wire logic [smlc_pkg::LENGTH_BITS-1:0]      pattern_length,
   input  wire logic [8*smlc_pkg::CFG_BYTES-1:0]      pattern_bytes,
   output smlc_pkg::cell_ctl_type                     ctl [MAX_PATTERN],
   output logic [LEN_W-1:0]                           active_len
);

   localparam int RAW_W = smlc_pkg::LENGTH_BITS + 1;

   logic [RAW_W-1:0]         raw_len;
   logic [LEN_W-1:0]         len_in;
   logic [LEN_W-1:0]         len_ff;
   logic [LEN_W-1:0]         shift_amt;
   logic [8*MAX_PATTERN-1:0] reversed;
   logic [8*MAX_PATTERN-1:0] aligned;
   smlc_pkg::cell_ctl_type   ctl_in [MAX_PATTERN];
   smlc_pkg::cell_ctl_type   ctl_ff [MAX_PATTERN];

   // zero length acts as one, long lengths stop at the window size
   assign raw_len = {1'b0, pattern_length};
   always_comb begin
      if (raw_len == '0) begin
         len_in = LEN_W'(1);
      end else if (raw_len > RAW_W'(MAX_PATTERN)) begin
         len_in = LEN_W'(MAX_PATTERN);
      end else begin
         len_in = LEN_W'(raw_len);
      end
   end

   // pattern in reverse order; bytes beyond the configured ones are zero
   for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_rev
      if (MAX_PATTERN - 1 - k < smlc_pkg::CFG_BYTES) begin : g_cfg
         assign reversed[8*k +: 8] = pattern_bytes[8*(MAX_PATTERN-1-k) +: 8];
      end else begin : g_zero
         assign reversed[8*k +: 8] = 8'h00;
      end
   end

   // cell k compares against pattern byte len-1-k
   assign shift_amt = LEN_W'(MAX_PATTERN) - len_in;
   assign aligned   = reversed >> {shift_amt, 3'b000};

   always_comb begin
      for (int k = 0; k < MAX_PATTERN; k++) begin
         ctl_in[k].pat  = aligned[8*k +: 8];
         ctl_in[k].used = LEN_W'(k) < len_in;
         ctl_in[k].pick = LEN_W'(k) == LEN_W'(len_in - 1'b1);
      end
   end

   // registered every cycle so the compare path starts at flops
   always_ff @(posedge clock) begin
      len_ff <= len_in;
      for (int k = 0; k < MAX_PATTERN; k++) begin
         ctl_ff[k] <= ctl_in[k];
      end
   end

   assign ctl        = ctl_ff;
   assign active_len = len_ff;

endmodule

`default_nettype wire

FILE: hdl/substring_match_with_line_column.sv
// streaming substring matcher reporting line, column and end offset of every hit
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  req_data_byte, req_start_of_text
//   rsp      out        rsp_valid / rsp_ready  rsp_line_number, rsp_start_column, rsp_end_offset
//   csr      in         csr_valid / csr_ready  csr_index, csr_data
//
// one byte per cycle while no hit is stalled: an accepted byte shifts the cell chain, then
// all cells compare against the aligned pattern in parallel and a hit loads the output register
// a hit is held in the output register while it is on rsp
// a hit that finds the output register still full holds the chain and drops req_ready
// reset is synchronous: pattern length 1, pattern bytes zero, counters cleared
// csr writes are always taken; a write passes the configuration and align registers before the compare uses it
`timescale 1ns / 1ps
`default_nettype none

module substring_match_with_line_column #(
   parameter int MAX_PATTERN = smlc_pkg::MAX_PATTERN_DEF,
   parameter int LINE_BITS   = smlc_pkg::LINE_BITS_DEF,
   parameter int COLUMN_BITS = smlc_pkg::COLUMN_BITS_DEF
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic [7:0]                             req_data_byte,
   input  wire logic                                   req_start_of_text,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic [smlc_pkg::LINE_OUT_BITS-1:0]          rsp_line_number,
   output logic [smlc_pkg::COLUMN_OUT_BITS-1:0]        rsp_start_column,
   output logic [smlc_pkg::OFFSET_BITS-1:0]            rsp_end_offset,
   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic [smlc_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  wire logic [smlc_pkg::CSR_DATA_BITS-1:0]     csr_data
);

   localparam int LEN_W    = $clog2(MAX_PATTERN + 1);
   localparam int LINE_EXT = (LINE_BITS > smlc_pkg::LINE_OUT_BITS) ?
                             LINE_BITS : smlc_pkg::LINE_OUT_BITS;
   localparam int COL_EXT  = (COLUMN_BITS > smlc_pkg::COLUMN_OUT_BITS) ?
                             COLUMN_BITS : smlc_pkg::COLUMN_OUT_BITS;
   localparam logic [LINE_BITS-1:0]   LINE_MAX   = '1;
   localparam logic [COLUMN_BITS-1:0] COLUMN_MAX = '1;
   localparam logic [LINE_EXT-1:0] LINE_CLAMP =
      LINE_EXT'({smlc_pkg::LINE_OUT_BITS{1'b1}});
   localparam logic [COL_EXT-1:0] COL_CLAMP =
      COL_EXT'({smlc_pkg::COLUMN_OUT_BITS{1'b1}});

   // configuration registers
   logic [smlc_pkg::LENGTH_BITS-1:0]   pattern_length_ff;
   logic [smlc_pkg::CSR_DATA_BITS-1:0] pattern_word_ff [smlc_pkg::PATTERN_WORDS];
   logic [8*smlc_pkg::CFG_BYTES-1:0]   pattern_flat;

   // stream counters
   logic [LINE_BITS-1:0]           line_count_ff, line_count_in, base_line;
   logic [COLUMN_BITS-1:0]         column_count_ff, column_count_in, base_column;
   logic [smlc_pkg::OFFSET_BITS-1:0] offset_ff, offset_in, base_offset;
   logic [LEN_W-1:0]               bytes_seen_ff, bytes_seen_in, base_seen;

   // compare stage
   logic                             s1_valid_ff, s1_valid_in;
   logic                             s1_line_sat_ff;
   logic [smlc_pkg::OFFSET_BITS-1:0] s1_offset_ff;

   // output register
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [smlc_pkg::LINE_OUT_BITS-1:0]   rsp_line_ff;
   logic [smlc_pkg::COLUMN_OUT_BITS-1:0] rsp_column_ff;
   logic [smlc_pkg::OFFSET_BITS-1:0]     rsp_offset_ff;

   // cell chain
   smlc_pkg::cell_ctl_type ctl [MAX_PATTERN];
   logic [LEN_W-1:0]       active_len;
   logic [7:0]             cell_byte   [MAX_PATTERN];
   logic [COLUMN_BITS-1:0] cell_column [MAX_PATTERN];
   logic [LINE_BITS-1:0]   cell_line   [MAX_PATTERN];
   logic [COLUMN_BITS-1:0] pick_column [MAX_PATTERN];
   logic [LINE_BITS-1:0]   pick_line   [MAX_PATTERN];
   logic [MAX_PATTERN-1:0] cell_match;

   logic                   accept, out_free, hit, s1_fire;
   logic [COLUMN_BITS-1:0] start_column;
   logic [LINE_BITS-1:0]   start_line;
   logic [LINE_BITS-1:0]   line_value;
   logic [LINE_EXT-1:0]    line_wide;
   logic [COL_EXT-1:0]     column_wide;

   // configuration writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_length_ff <= smlc_pkg::LENGTH_BITS'(1);
         for (int w = 0; w < smlc_pkg::PATTERN_WORDS; w++) begin
            pattern_word_ff[w] <= '0;
         end
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            smlc_pkg::CSR_LENGTH: begin
               pattern_length_ff <= csr_data[smlc_pkg::LENGTH_BITS-1:0];
            end
            smlc_pkg::CSR_BYTES_0_7: begin
               pattern_word_ff[0] <= csr_data;
            end
            smlc_pkg::CSR_BYTES_8_15: begin
               pattern_word_ff[1] <= csr_data;
            end
            smlc_pkg::CSR_BYTES_16_23: begin
               pattern_word_ff[2] <= csr_data;
            end
            smlc_pkg::CSR_BYTES_24_31: begin
               pattern_word_ff[3] <= csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   assign pattern_flat = {pattern_word_ff[3], pattern_word_ff[2],
                          pattern_word_ff[1], pattern_word_ff[0]};

   smlc_align #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_align (
      .clock          (clock),
      .pattern_length (pattern_length_ff),
      .pattern_bytes  (pattern_flat),
      .ctl            (ctl),
      .active_len     (active_len)
   );

   // handshake: a pending hit waits for the output register
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_fire   = s1_valid_ff && (out_free || !hit);
   assign req_ready = !s1_valid_ff || s1_fire;
   assign accept    = req_valid && req_ready;

   // counters as seen by this item, after an optional start of text
   assign base_line   = req_start_of_text ? '0 : line_count_ff;
   assign base_column = req_start_of_text ? '0 : column_count_ff;
   assign base_offset = req_start_of_text ? '0 : offset_ff;
   assign base_seen   = req_start_of_text ? '0 : bytes_seen_ff;

   always_comb begin
      line_count_in   = base_line;
      column_count_in = base_column;
      if (req_data_byte == smlc_pkg::NEWLINE_BYTE) begin
         column_count_in = '0;
         if (base_line != LINE_MAX) begin
            line_count_in = base_line + 1'b1;
         end
      end else if (base_column != COLUMN_MAX) begin
         column_count_in = base_column + 1'b1;
      end
      offset_in     = base_offset + 1'b1;
      bytes_seen_in = (base_seen < LEN_W'(MAX_PATTERN)) ? LEN_W'(base_seen + 1'b1) : base_seen;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_count_ff   <= '0;
         column_count_ff <= '0;
         offset_ff       <= '0;
         bytes_seen_ff   <= '0;
      end else if (accept) begin
         line_count_ff   <= line_count_in;
         column_count_ff <= column_count_in;
         offset_ff       <= offset_in;
         bytes_seen_ff   <= bytes_seen_in;
      end
   end

   // the chain: cell 0 takes the new byte, each cell hands its contents onward
   for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
      logic [7:0]             byte_prev;
      logic [COLUMN_BITS-1:0] column_prev;
      logic [LINE_BITS-1:0]   line_prev;

      if (k == 0) begin : g_head
         assign byte_prev   = req_data_byte;
         assign column_prev = base_column;
         assign line_prev   = base_line;
      end else begin : g_link
         assign byte_prev   = cell_byte[k-1];
         assign column_prev = cell_column[k-1];
         assign line_prev   = cell_line[k-1];
      end

      smlc_cell #(
         .LINE_BITS   (LINE_BITS),
         .COLUMN_BITS (COLUMN_BITS)
      ) u_cell (
         .clock       (clock),
         .shift_en    (accept),
         .byte_prev   (byte_prev),
         .column_prev (column_prev),
         .line_prev   (line_prev),
         .ctl         (ctl[k]),
         .byte_out    (cell_byte[k]),
         .column_out  (cell_column[k]),
         .line_out    (cell_line[k]),
         .match       (cell_match[k]),
         .column_pick (pick_column[k]),
         .line_pick   (pick_line[k])
      );
   end

   // compare stage state for the byte now at the head of the chain
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   assign s1_valid_in = accept ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_line_sat_ff <= (base_line == LINE_MAX);
         s1_offset_ff   <= base_offset;
      end
   end

   // hit when every used cell agrees and the window is full enough
   assign hit = (&cell_match) && (bytes_seen_ff >= active_len);

   // start position from the cell holding the first matched byte
   always_comb begin
      start_column = '0;
      start_line   = '0;
      for (int k = 0; k < MAX_PATTERN; k++) begin
         start_column = start_column | pick_column[k];
         start_line   = start_line | pick_line[k];
      end
   end

   // a saturated line counter reports its maximum, otherwise start line is 1-based
   assign line_value  = s1_line_sat_ff ? LINE_MAX : LINE_BITS'(start_line + 1'b1);
   assign line_wide   = LINE_EXT'(line_value);
   assign column_wide = COL_EXT'(start_column);

   // output register
   always_comb begin
      if (s1_fire && hit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && hit) begin
         rsp_line_ff   <= (line_wide > LINE_CLAMP) ? '1 :
                          line_wide[smlc_pkg::LINE_OUT_BITS-1:0];
         rsp_column_ff <= (column_wide > COL_CLAMP) ? '1 :
                          column_wide[smlc_pkg::COLUMN_OUT_BITS-1:0];
         rsp_offset_ff <= s1_offset_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_line_number  = rsp_line_ff;
   assign rsp_start_column = rsp_column_ff;
   assign rsp_end_offset   = rsp_offset_ff;

   // start of text leaves exactly one byte in the window
   assert property (@(posedge clock) disable iff (reset)
      accept && req_start_of_text |=> bytes_seen_ff == LEN_W'(1))
      else $error("window fill count wrong after start of text");

   // fill count never passes the window size
   assert property (@(posedge clock) disable iff (reset)
      bytes_seen_ff <= LEN_W'(MAX_PATTERN))
      else $error("window fill count overflow");

   // a new result only comes from an evaluated item
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff))
      else $error("result without a pending item");

   // a stalled hit keeps its item and its offset
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_fire |=> s1_valid_ff && $stable(s1_offset_ff))
      else $error("stalled item lost");

endmodule

`default_nettype wire

FILE: test/substring_match_with_line_column_test.sv
// self-checking testbench for the streaming substring matcher with line and column report
`timescale 1ns / 1ps

module substring_match_with_line_column_test;
   import smlc_pkg::*;

   localparam int     WINDOW       = MAX_PATTERN_DEF;
   localparam int     IDLE_PAD     = 8;
   localparam int     PHASE_ITEMS  = 120;
   localparam int     RANDOM_ITEMS = 1200;
   localparam longint RUN_LIMIT_NS = 10_000_000;

   typedef struct packed {
      logic [LINE_OUT_BITS-1:0]   line_number;
      logic [COLUMN_OUT_BITS-1:0] start_column;
      logic [OFFSET_BITS-1:0]     end_offset;
   } match_report_type;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   logic [7:0]                 req_data_byte;
   logic                       req_start_of_text;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [LINE_OUT_BITS-1:0]   rsp_line_number;
   logic [COLUMN_OUT_BITS-1:0] rsp_start_column;
   logic [OFFSET_BITS-1:0]     rsp_end_offset;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [CSR_INDEX_BITS-1:0]  csr_index;
   logic [CSR_DATA_BITS-1:0]   csr_data;

   // shadow of the configuration registers
   logic [LENGTH_BITS-1:0]     cfg_length;
   logic [CSR_DATA_BITS-1:0]   cfg_words [PATTERN_WORDS];

   // shadow of the text position: window newest first, counters
   logic [7:0]                 win_byte [WINDOW];
   logic [COLUMN_OUT_BITS-1:0] win_col  [WINDOW];
   int                         win_fill;
   logic [LINE_OUT_BITS-1:0]   line_count;
   logic [COLUMN_OUT_BITS-1:0] column_count;
   logic [OFFSET_BITS-1:0]     stream_offset;

   match_report_type expected_hits [$];

   int   error_count = 0;
   int   items_sent  = 0;
   int   burst_left  = 0;
   int   gap_max     = 0;
   int   stall_pct   = 0;
   int   stall_max   = 0;
   int   stall_left  = 0;
   int   hold_left   = 0;
   logic sot_pending = 1'b0;

   substring_match_with_line_column u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_start_of_text (req_start_of_text),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_line_number   (rsp_line_number),
      .rsp_start_column  (rsp_start_column),
      .rsp_end_offset    (rsp_end_offset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("substring_match_with_line_column regression: fail");
      $finish;
   end

   // pattern length in effect: zero acts as one, oversize clamps to the window
   function automatic int active_length();
      int n;
      n = cfg_length;
      if (n == 0) n = 1;
      if (n > WINDOW) n = WINDOW;
      return n;
   endfunction

   function automatic logic [7:0] pattern_byte(int idx);
      logic [CSR_DATA_BITS-1:0] w;
      w = cfg_words[idx / 8];
      return w[(idx % 8) * 8 +: 8];
   endfunction

   task automatic clear_text_position();
      for (int i = 0; i < WINDOW; i++) begin
         win_byte[i] = '0;
         win_col[i]  = '0;
      end
      win_fill      = 0;
      line_count    = '0;
      column_count  = '0;
      stream_offset = '0;
   endtask

   // advance the text shadow by one byte and queue the report of a completed hit
   task automatic scan_byte(input logic [7:0] d, input logic sot);
      int                       len;
      bit                       hit;
      logic [LINE_OUT_BITS-1:0] nl_count;
      match_report_type         rep;
      if (sot) clear_text_position();
      for (int i = WINDOW - 1; i > 0; i--) begin
         win_byte[i] = win_byte[i-1];
         win_col[i]  = win_col[i-1];
      end
      win_byte[0] = d;
      win_col[0]  = column_count;
      if (win_fill < WINDOW) win_fill++;
      len      = active_length();
      hit      = (win_fill >= len);
      nl_count = '0;
      for (int k = 0; k < len && hit; k++) begin
         if (win_byte[k] != pattern_byte(len - 1 - k)) begin
            hit = 1'b0;
         end else if (k > 0 && win_byte[k] == NEWLINE_BYTE) begin
            nl_count++;
         end
      end
      if (hit) begin
         // newlines inside the match move the start line back
         if (line_count == '1) begin
            rep.line_number = '1;
         end else begin
            rep.line_number = ((line_count >= nl_count) ? line_count - nl_count : '0) + 1'b1;
         end
         rep.start_column = win_col[len-1];
         rep.end_offset   = stream_offset;
         expected_hits.push_back(rep);
      end
      if (d == NEWLINE_BYTE) begin
         if (line_count != '1) line_count++;
         column_count = '0;
      end else if (column_count != '1) begin
         column_count++;
      end
      stream_offset++;
   endtask

   // csr write; valid stays up so that writes can follow back to back
   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_LENGTH:      cfg_length   = value[LENGTH_BITS-1:0];
         CSR_BYTES_0_7:   cfg_words[0] = value;
         CSR_BYTES_8_15:  cfg_words[1] = value;
         CSR_BYTES_16_23: cfg_words[2] = value;
         CSR_BYTES_24_31: cfg_words[3] = value;
         default: ;
      endcase
   endtask

   // pattern byte i sits in bytes[8*i +: 8]; junk above the length field
   task automatic load_pattern(input logic [LENGTH_BITS-1:0] len,
                               input logic [CFG_BYTES*8-1:0] bytes);
      logic [CSR_DATA_BITS-1:0] len_word;
      len_word = {$urandom, $urandom};
      len_word[LENGTH_BITS-1:0] = len;
      write_csr(CSR_LENGTH, len_word);
      write_csr(CSR_BYTES_0_7, bytes[63:0]);
      write_csr(CSR_BYTES_8_15, bytes[127:64]);
      write_csr(CSR_BYTES_16_23, bytes[191:128]);
      write_csr(CSR_BYTES_24_31, bytes[255:192]);
      csr_valid <= 1'b0;
   endtask

   // offer one item, with random gaps between bursts
   task automatic send_item(input logic [7:0] d, input logic sot);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid         <= 1'b1;
      req_data_byte     <= d;
      req_start_of_text <= sot;
      do @(posedge clock); while (!req_ready);
      scan_byte(d, sot);
      burst_left--;
      items_sent++;
   endtask

   task automatic put_byte(input logic [7:0] d);
      send_item(d, sot_pending);
      sot_pending = 1'b0;
   endtask

   // wait for every expected report, then let the compare stage settle
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (expected_hits.size() != 0) @(posedge clock);
      repeat (IDLE_PAD) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_text_byte();
      logic [7:0] b;
      case ($urandom_range(0, 7))
         0:       b = 8'h61;
         1:       b = 8'h62;
         2:       b = NEWLINE_BYTE;
         3:       b = 8'h00;
         4:       b = 8'hFF;
         default: b = 8'($urandom_range(0, 255));
      endcase
      return b;
   endfunction

   // receiver: long hold when asked, otherwise random stall runs
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
         rsp_ready  <= 1'b0;
         stall_left = $urandom_range(0, stall_max);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // compare each accepted report with the oldest expected one
   always @(posedge clock) begin
      match_report_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_hits.size() == 0) begin
            $error("unexpected report: line %0d column %0d offset %0d",
                   rsp_line_number, rsp_start_column, rsp_end_offset);
            error_count++;
         end else begin
            want = expected_hits.pop_front();
            if (rsp_line_number !== want.line_number) begin
               $error("line_number: expected %0d, got %0d", want.line_number,
                      rsp_line_number);
               error_count++;
            end
            if (rsp_start_column !== want.start_column) begin
               $error("start_column: expected %0d, got %0d", want.start_column,
                      rsp_start_column);
               error_count++;
            end
            if (rsp_end_offset !== want.end_offset) begin
               $error("end_offset: expected %0d, got %0d", want.end_offset,
                      rsp_end_offset);
               error_count++;
            end
         end
      end
   end

   // out of reset the pattern is one zero byte
   task automatic test_reset_defaults();
      send_item(8'h00, 1'b0);
      send_item(8'hFF, 1'b0);
      wait_for_drain();
   endtask

   // length zero acts as one; writes to unused indexes change nothing
   task automatic test_length_zero_and_unused_index();
      load_pattern(6'd0, 256'(NEWLINE_BYTE));
      send_item(NEWLINE_BYTE, 1'b0);
      send_item(8'h78, 1'b0);
      send_item(NEWLINE_BYTE, 1'b1);
      wait_for_drain();
      for (int i = CSR_BYTES_24_31 + 1; i < 2 ** CSR_INDEX_BITS; i++) begin
         write_csr(CSR_INDEX_BITS'(i), {$urandom, $urandom});
      end
      csr_valid <= 1'b0;
      send_item(NEWLINE_BYTE, 1'b0);
      wait_for_drain();
   endtask

   // a newline inside the pattern: the hit reports the line where it starts
   task automatic test_newline_in_pattern();
      load_pattern(6'd3, 256'({8'h62, NEWLINE_BYTE, 8'h61}));
      send_item(8'h61, 1'b1);
      send_item(NEWLINE_BYTE, 1'b0);
      send_item(8'h62, 1'b0);
      send_item(8'h61, 1'b0);
      send_item(NEWLINE_BYTE, 1'b0);
      send_item(8'h62, 1'b0);
      send_item(8'h78, 1'b0);
      wait_for_drain();
   endtask

   // zero bytes after a text start must not match the cleared window; overlaps
   task automatic test_short_window_and_overlap();
      load_pattern(6'd2, '0);
      send_item(8'h00, 1'b1);
      send_item(8'h00, 1'b0);
      send_item(8'h00, 1'b0);
      wait_for_drain();
      load_pattern(6'd2, 256'({8'h00, 8'hFF}));
      send_item(8'hFF, 1'b0);
      send_item(8'h00, 1'b0);
      wait_for_drain();
   endtask

   // random patterns and texts built mostly from whole and broken occurrences
   task automatic test_random_text(input int total);
      int                      first;
      int                      start;
      int                      phase;
      int                      plen;
      int                      cut;
      logic [LENGTH_BITS-1:0]  len_cfg;
      logic [CFG_BYTES*8-1:0]  pat;
      first = items_sent;
      phase = 0;
      while (items_sent - first < total) begin
         wait_for_drain();
         for (int i = 0; i < CFG_BYTES; i++) pat[i*8 +: 8] = pick_text_byte();
         case (phase)
            0: len_cfg = 6'd32;
            1: len_cfg = 6'd63;
            2: len_cfg = 6'd1;
            3: begin
               len_cfg = 6'd4;
               pat     = '1;
            end
            default: begin
               case ($urandom_range(0, 9))
                  0, 1, 2, 3, 4, 5: len_cfg = 6'($urandom_range(1, 4));
                  6, 7:             len_cfg = 6'($urandom_range(5, 16));
                  8:                len_cfg = 6'($urandom_range(17, 32));
                  default: len_cfg = $urandom_range(0, 1) ? 6'd0 : 6'($urandom_range(33, 63));
               endcase
            end
         endcase
         load_pattern(len_cfg, pat);
         // traffic shape for this phase; phase 0 runs without idling
         gap_max   = (phase == 0) ? 0 : $urandom_range(0, 3) * 3;
         stall_pct = (phase == 0) ? 0 : $urandom_range(0, 2) * 20;
         stall_max = $urandom_range(0, 6);
         plen  = active_length();
         start = items_sent;
         while (items_sent - start < PHASE_ITEMS) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4: begin
                  for (int k = 0; k < plen; k++) put_byte(pattern_byte(k));
               end
               5, 6: begin
                  cut = $urandom_range(0, plen - 1);
                  for (int k = 0; k < cut; k++) put_byte(pattern_byte(k));
                  put_byte(pick_text_byte());
               end
               7, 8: begin
                  repeat ($urandom_range(1, 6)) put_byte(pick_text_byte());
               end
               default: sot_pending = 1'b1;
            endcase
         end
         phase++;
      end
      wait_for_drain();
   endtask

   // receiver holds off while single-byte hits keep coming: input must stall
   task automatic test_output_backpressure();
      load_pattern(6'd1, 256'h61);
      gap_max   = 0;
      stall_pct = 0;
      hold_left = 300;
      repeat (200) send_item(8'h61, 1'b0);
      wait_for_drain();
   endtask

   // one long line: start columns climb along it, then restart after a newline
   task automatic test_columns_on_long_line();
      logic [7:0] b;
      load_pattern(6'd2, 256'({8'h62, 8'h61}));
      gap_max   = 0;
      stall_pct = 0;
      for (int i = 0; i < 70; i++) begin
         b = 8'($urandom_range(0, 255));
         if (b == NEWLINE_BYTE) b = 8'h20;
         if (i == 10 || i == 40 || i == 68) begin
            b = 8'h61;
         end else if (i == 11 || i == 41 || i == 69) begin
            b = 8'h62;
         end
         send_item(b, i == 0);
      end
      send_item(NEWLINE_BYTE, 1'b0);
      send_item(8'h61, 1'b0);
      send_item(8'h62, 1'b0);
      wait_for_drain();
   endtask

   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_data_byte     = '0;
      req_start_of_text = 1'b0;
      csr_valid         = 1'b0;
      csr_index         = CSR_LENGTH;
      csr_data          = '0;
      cfg_length        = 6'd1;
      for (int i = 0; i < PATTERN_WORDS; i++) cfg_words[i] = '0;
      clear_text_position();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_length_zero_and_unused_index();
      test_newline_in_pattern();
      test_short_window_and_overlap();
      test_random_text(RANDOM_ITEMS);
      test_output_backpressure();
      test_columns_on_long_line();

      if (error_count == 0) begin
         $display("substring_match_with_line_column regression: pass");
      end else begin
         $display("substring_match_with_line_column regression: fail");
      end
      $finish;
   end

endmodule
